### src/euclidean_distance_bounded_assert.svh
// ----------------------------------------------------------------------------
// Euclidean distance assertion macros
// Shared property forms for the checks in the distance block.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_BOUNDED_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_BOUNDED_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define EDB_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("edb assertion failed");

// next-cycle implication, disabled while reset is low
`define EDB_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("edb assertion failed");

`endif

### src/edb_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean distance package
// Shared widths, defaults and the control group that runs down the root chain.
// ----------------------------------------------------------------------------
package edb_pkg;

  localparam int BOUND_W          = 24;
  localparam int DIST_W           = 48;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF    = 48;

  // control that travels beside the sum through the chain
  typedef struct packed {
    logic valid;
    logic cut_short;
    logic saturated;
  } edb_ctl_t;

  function automatic int edb_max3(input int x, input int y, input int z);
    int m;
    m = (x > y) ? x : y;
    return (m > z) ? m : z;
  endfunction

endpackage

### src/edb_acc.sv
// ----------------------------------------------------------------------------
// Euclidean distance accumulator
// Difference, squaring and bounded saturating accumulation of one vector.
// ----------------------------------------------------------------------------
`include "euclidean_distance_bounded_assert.svh"

module edb_acc
  import edb_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    take,
  input  logic [SAMPLE_WIDTH-1:0] a_element,
  input  logic [SAMPLE_WIDTH-1:0] b_element,
  input  logic [BOUND_W-1:0]      bound,
  input  logic                    use_bound,
  input  logic                    last,
  output edb_ctl_t                res_ctl,
  output logic [SUM_WIDTH-1:0]    res_sum
);

  localparam int AW = edb_max3(SUM_WIDTH, 2 * SAMPLE_WIDTH, 2 * BOUND_W) + 1;
  localparam logic [AW-1:0] SUM_MAX_W = {{(AW - SUM_WIDTH){1'b0}}, {SUM_WIDTH{1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic at_first_r;

  // stage 1: magnitude of the difference
  logic                    s1_valid_r, s1_first_r, s1_last_r, s1_use_r;
  logic [SAMPLE_WIDTH-1:0] s1_mag_r;
  logic [BOUND_W-1:0]      s1_bound_r;
  logic [SAMPLE_WIDTH:0]   diff;
  logic [SAMPLE_WIDTH:0]   diff_abs;

  // stage 2: squares
  logic                        s2_valid_r, s2_first_r, s2_last_r, s2_use_r;
  logic [2*SAMPLE_WIDTH-1:0]   s2_sq_r;
  logic [2*BOUND_W-1:0]        s2_bsq_r;

  // accumulator state
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic [SUM_WIDTH-1:0] bsq_r, bsq_nxt;
  logic                 active_r, active_nxt;
  logic                 frozen_r, frozen_nxt;
  logic                 clipped_r, clipped_nxt;

  logic [SUM_WIDTH-1:0] base_sum, base_bsq, new_sum;
  logic                 base_active, base_frozen, base_clipped, new_frozen, new_clipped;
  logic [AW-1:0]        wide_sum, bsq_ext;

  edb_ctl_t             res_ctl_r;
  logic [SUM_WIDTH-1:0] res_sum_r;

  assign diff     = {a_element[SAMPLE_WIDTH-1], a_element} - {b_element[SAMPLE_WIDTH-1], b_element};
  assign diff_abs = diff[SAMPLE_WIDTH] ? (~diff + {{SAMPLE_WIDTH{1'b0}}, 1'b1}) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_first_r <= 1'b1;
    end else if (take) begin
      at_first_r <= last;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= take;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= at_first_r;
      s1_last_r  <= last;
      s1_use_r   <= use_bound;
      s1_mag_r   <= diff_abs[SAMPLE_WIDTH-1:0];
      s1_bound_r <= bound;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_use_r   <= s1_use_r;
      s2_sq_r    <= (2*SAMPLE_WIDTH)'(s1_mag_r) * (2*SAMPLE_WIDTH)'(s1_mag_r);
      s2_bsq_r   <= (2*BOUND_W)'(s1_bound_r) * (2*BOUND_W)'(s1_bound_r);
    end
  end

  always_comb begin
    bsq_ext      = AW'(s2_bsq_r);
    if (bsq_ext > SUM_MAX_W) bsq_ext = SUM_MAX_W;
    // first element of a vector starts from a clean state
    base_sum     = s2_first_r ? '0 : sum_r;
    base_bsq     = s2_first_r ? bsq_ext[SUM_WIDTH-1:0] : bsq_r;
    base_active  = s2_first_r ? s2_use_r : active_r;
    base_frozen  = s2_first_r ? 1'b0 : frozen_r;
    base_clipped = s2_first_r ? 1'b0 : clipped_r;
    wide_sum     = AW'(base_sum) + AW'(s2_sq_r);
    new_sum      = base_sum;
    new_clipped  = base_clipped;
    new_frozen   = base_frozen;
    if (!base_frozen) begin
      if (wide_sum > SUM_MAX_W) begin
        new_sum     = SUM_MAX;
        new_clipped = 1'b1;
      end else begin
        new_sum = wide_sum[SUM_WIDTH-1:0];
      end
      new_frozen = base_active && (new_sum > base_bsq);
    end
    sum_nxt     = sum_r;
    bsq_nxt     = bsq_r;
    active_nxt  = active_r;
    frozen_nxt  = frozen_r;
    clipped_nxt = clipped_r;
    if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        sum_nxt     = '0;
        bsq_nxt     = '0;
        active_nxt  = 1'b0;
        frozen_nxt  = 1'b0;
        clipped_nxt = 1'b0;
      end else begin
        sum_nxt     = new_sum;
        bsq_nxt     = base_bsq;
        active_nxt  = base_active;
        frozen_nxt  = new_frozen;
        clipped_nxt = new_clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      bsq_r     <= '0;
      active_r  <= 1'b0;
      frozen_r  <= 1'b0;
      clipped_r <= 1'b0;
      res_ctl_r <= '0;
    end else begin
      sum_r     <= sum_nxt;
      bsq_r     <= bsq_nxt;
      active_r  <= active_nxt;
      frozen_r  <= frozen_nxt;
      clipped_r <= clipped_nxt;
      if (adv) begin
        res_ctl_r.valid     <= s2_valid_r && s2_last_r;
        res_ctl_r.cut_short <= new_frozen;
        res_ctl_r.saturated <= new_clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_sum_r <= new_sum;
    end
  end

  assign res_ctl = res_ctl_r;
  assign res_sum = res_sum_r;

  `EDB_ASSERT_IMP(a_frozen_needs_bound, clk, rst_n, frozen_r, active_r)
  `EDB_ASSERT_IMP(a_clipped_at_max, clk, rst_n, clipped_r, sum_r == SUM_MAX)
  `EDB_ASSERT_NXT(a_clear_after_last, clk, rst_n, adv && s2_valid_r && s2_last_r,
    sum_r == '0 && !frozen_r && !clipped_r && !active_r)

endmodule

### src/edb_root_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root, registered toward the next cell.
// ----------------------------------------------------------------------------
module edb_root_cell
  import edb_pkg::*;
#(
  parameter int SUM_WIDTH = SUM_WIDTH_DEF,
  parameter int BIT_POS   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  edb_ctl_t             ctl_i,
  input  logic [SUM_WIDTH-1:0] rem_i,
  input  logic [SUM_WIDTH-1:0] root_i,
  input  logic [SUM_WIDTH-1:0] raw_i,
  output edb_ctl_t             ctl_o,
  output logic [SUM_WIDTH-1:0] rem_o,
  output logic [SUM_WIDTH-1:0] root_o,
  output logic [SUM_WIDTH-1:0] raw_o
);

  localparam logic [SUM_WIDTH:0] BIT_VAL = {{SUM_WIDTH{1'b0}}, 1'b1} << BIT_POS;

  edb_ctl_t             ctl_r;
  logic [SUM_WIDTH-1:0] rem_r, root_r, raw_r;
  logic [SUM_WIDTH-1:0] rem_nxt, root_nxt;
  logic [SUM_WIDTH:0]   trial;
  logic                 fits;

  always_comb begin
    trial = {1'b0, root_i} + BIT_VAL;
    fits  = {1'b0, rem_i} >= trial;
    if (fits) begin
      rem_nxt  = rem_i - trial[SUM_WIDTH-1:0];
      root_nxt = (root_i >> 1) + BIT_VAL[SUM_WIDTH-1:0];
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      raw_r  <= raw_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign raw_o  = raw_r;

endmodule

### src/euclidean_distance_bounded.sv
// ----------------------------------------------------------------------------
// Bounded Euclidean distance
// Streams element pairs of two vectors and returns one distance per vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one element pair per transfer, in_tlast on the final
//   pair of the vectors. bound and use_bound are taken from the first pair.
//   Result channel out_*: one transfer per vector, on the pair with in_tlast.
//   cfg_we/cfg_wdata set skip_root (1 = squared sum, 0 = floor square root);
//   write it only while no vector is in flight.
// Throughput: one element pair per cycle while the output is not stalled, set by
//   the single multiply and accumulate pass; the square root is a chain of
//   (SUM_WIDTH+1)/2 cells, one root bit each, so back-to-back vectors also run
//   at one pair per cycle when not stalled.
// Reset: synchronous, clears the pipeline valid bits, the accumulator and
//   skip_root; the next pair starts a new vector. No clearing pass.
// Stall: while out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module euclidean_distance_bounded
  import edb_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // fields from bit 0: a_element, b_element, bound, use_bound, zero pad
  input  logic [((2*SAMPLE_WIDTH+BOUND_W+1+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  input  logic in_tlast,
  output logic in_tready,
  // fields from bit 0: distance, cut_short, saturated, zero pad
  output logic [((DIST_W+2+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int CELLS     = (SUM_WIDTH + 1) / 2;
  localparam int IN_BITS   = 2 * SAMPLE_WIDTH + BOUND_W + 1;
  localparam int OUT_TDATA = ((DIST_W + 2 + 7) / 8) * 8;

  logic adv;
  logic take;
  logic skip_root_r;

  edb_ctl_t             ctl_w  [0:CELLS];
  logic [SUM_WIDTH-1:0] rem_w  [0:CELLS];
  logic [SUM_WIDTH-1:0] root_w [0:CELLS];
  logic [SUM_WIDTH-1:0] raw_w  [0:CELLS];

  logic                 out_valid_r;
  logic [DIST_W-1:0]    dist_r;
  logic                 cut_r, sat_r;
  logic [SUM_WIDTH-1:0] dist_sel;
  logic [SUM_WIDTH+DIST_W-1:0] dist_ext;

  // advance the whole pipeline whenever the output register can move
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign take      = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_root_r <= 1'b0;
    end else if (cfg_we) begin
      skip_root_r <= cfg_wdata;
    end
  end

  edb_acc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .take      (take),
    .a_element (in_tdata[SAMPLE_WIDTH-1:0]),
    .b_element (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .bound     (in_tdata[2*SAMPLE_WIDTH+BOUND_W-1:2*SAMPLE_WIDTH]),
    .use_bound (in_tdata[IN_BITS-1]),
    .last      (in_tlast),
    .res_ctl   (ctl_w[0]),
    .res_sum   (raw_w[0])
  );

  // root chain starts from the full sum as remainder and a zero root
  assign rem_w[0]  = raw_w[0];
  assign root_w[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    edb_root_cell #(
      .SUM_WIDTH (SUM_WIDTH),
      .BIT_POS   (2 * (CELLS - 1 - k))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (ctl_w[k]),
      .rem_i  (rem_w[k]),
      .root_i (root_w[k]),
      .raw_i  (raw_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .root_o (root_w[k+1]),
      .raw_o  (raw_w[k+1])
    );
  end

  // pick sum or root, then fit it to the 48-bit distance field
  assign dist_sel = skip_root_r ? raw_w[CELLS] : root_w[CELLS];
  assign dist_ext = {{DIST_W{1'b0}}, dist_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_w[CELLS].valid;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_ext[DIST_W-1:0];
      cut_r  <= ctl_w[CELLS].cut_short;
      sat_r  <= ctl_w[CELLS].saturated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA - DIST_W - 2){1'b0}}, sat_r, cut_r, dist_r};

endmodule
